/* design/dtp_pkg.sv */
// ----------------------------------------------------------------------------
// dtp_pkg: shared types and unit tables
// Token transaction structs, status codes and the per-unit multiplier split
// (odd factor and left shift) for the duration text parser.
// ----------------------------------------------------------------------------
package dtp_pkg;

	localparam int CNT_W   = 64;
	localparam int ODD_W   = 25;
	localparam int SHIFT_W = 4;
	localparam int HALF_W  = CNT_W / 2;
	localparam int PART_W  = HALF_W + ODD_W;

	typedef enum logic [1:0] {
		ST_PARSED  = 2'd0,
		ST_PLAIN   = 2'd1,
		ST_INVALID = 2'd2,
		ST_EMPTY   = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		UNIT_NONE = 3'd0,
		UNIT_MS   = 3'd1,
		UNIT_S    = 3'd2,
		UNIT_M    = 3'd3,
		UNIT_H    = 3'd4,
		UNIT_D    = 3'd5,
		UNIT_W    = 3'd6,
		UNIT_Y    = 3'd7
	} unit_t;

	localparam logic [7:0] CH_M = 8'h6d;
	localparam logic [7:0] CH_S = 8'h73;
	localparam logic [7:0] CH_H = 8'h68;
	localparam logic [7:0] CH_D = 8'h64;
	localparam logic [7:0] CH_W = 8'h77;
	localparam logic [7:0] CH_Y = 8'h79;

	// finished token, produced by the scanner
	typedef struct packed {
		logic              mul;
		logic [CNT_W-1:0]  count;
		unit_t             unit;
		logic              last;
		status_t           status;
		logic [CNT_W-1:0]  plain;
		logic              sat;
	} tok_t;

	// partial products
	typedef struct packed {
		logic               mul;
		logic [PART_W-1:0]  hi;
		logic [PART_W-1:0]  lo;
		logic [SHIFT_W-1:0] shift;
		logic               last;
		status_t            status;
		logic [CNT_W-1:0]   plain;
		logic               sat;
	} part_t;

	// saturated product
	typedef struct packed {
		logic              mul;
		logic [CNT_W-1:0]  prod;
		logic              psat;
		logic              last;
		status_t           status;
		logic [CNT_W-1:0]  plain;
		logic              sat;
	} prod_t;

	function automatic unit_t unit_decode(input logic [1:0] len, input logic [7:0] first,
			input logic [7:0] second);
		unit_t u;
		u = UNIT_NONE;
		if (len == 2'd2 && first == CH_M && second == CH_S) begin
			u = UNIT_MS;
		end else if (len == 2'd1) begin
			case (first)
				CH_S: u = UNIT_S;
				CH_M: u = UNIT_M;
				CH_H: u = UNIT_H;
				CH_D: u = UNIT_D;
				CH_W: u = UNIT_W;
				CH_Y: u = UNIT_Y;
				default: u = UNIT_NONE;
			endcase
		end
		return u;
	endfunction

	// unit in ms = odd << shift
	function automatic logic [ODD_W-1:0] unit_odd(input unit_t u);
		logic [ODD_W-1:0] m;
		case (u)
			UNIT_MS: m = ODD_W'(1);
			UNIT_S:  m = ODD_W'(125);
			UNIT_M:  m = ODD_W'(1875);
			UNIT_H:  m = ODD_W'(28125);
			UNIT_D:  m = ODD_W'(84375);
			UNIT_W:  m = ODD_W'(590625);
			UNIT_Y:  m = ODD_W'(30796875);
			default: m = '0;
		endcase
		return m;
	endfunction

	function automatic logic [SHIFT_W-1:0] unit_shift(input unit_t u);
		logic [SHIFT_W-1:0] s;
		case (u)
			UNIT_MS: s = SHIFT_W'(0);
			UNIT_S:  s = SHIFT_W'(3);
			UNIT_M:  s = SHIFT_W'(5);
			UNIT_H:  s = SHIFT_W'(7);
			UNIT_D:  s = SHIFT_W'(10);
			UNIT_W:  s = SHIFT_W'(10);
			UNIT_Y:  s = SHIFT_W'(10);
			default: s = '0;
		endcase
		return s;
	endfunction

endpackage

/* design/dtp_scan.sv */
// ----------------------------------------------------------------------------
// dtp_scan: character scanner
// Input register plus the per-character token state; emits a transaction for
// every finished token with a nonzero count and a valid unit, and for every end of string.
// ----------------------------------------------------------------------------
module dtp_scan (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [7:0]    char_code,
	input  logic          is_last,
	output logic          tok_valid,
	input  logic          tok_ready,
	output dtp_pkg::tok_t tok
);
	import dtp_pkg::*;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'b001,
		PH_DIGITS  = 3'b010,
		PH_LETTERS = 3'b100
	} phase_t;

	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_A     = 8'h61;
	localparam logic [7:0] CH_Z     = 8'h7a;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0d;

	logic             v_s1;
	logic [7:0]       char_s1;
	logic             last_s1;
	logic             tok_valid_s2;
	tok_t             tok_s2;

	phase_t           phase_q, phase_n;
	logic [CNT_W-1:0] count_q, count_n;
	logic [7:0]       first_q, first_n;
	logic [7:0]       second_q, second_n;
	logic [1:0]       len_q, len_n;
	logic             only_q, only_n;
	logic             seen_q, seen_n;
	logic             inv_q, inv_n;
	logic             sat_q, sat_n;

	logic             consume;
	logic             space, dig, low;
	logic [CNT_W-1:0] base;
	logic [CNT_W+3:0] ext, m10;
	logic             csat;
	logic             fin_char, fin, tok_bad, mul, emit;
	unit_t            unit;
	status_t          status;

	assign consume  = v_s1 && (!tok_valid_s2 || tok_ready);
	assign in_ready = !v_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1 <= char_code;
			last_s1 <= is_last;
		end
	end

	always_comb begin
		space = (char_s1 == CH_SPACE) || (char_s1 >= CH_TAB && char_s1 <= CH_CR);
		dig   = (char_s1 >= CH_0) && (char_s1 <= CH_9);
		low   = (char_s1 >= CH_A) && (char_s1 <= CH_Z);
		base  = (phase_q == PH_DIGITS) ? count_q : '0;
		ext   = {4'b0, base};
		m10   = (ext << 3) + (ext << 1) + {{CNT_W{1'b0}}, char_s1[3:0]};
		csat  = |m10[CNT_W+3:CNT_W];

		phase_n  = phase_q;
		count_n  = count_q;
		first_n  = first_q;
		second_n = second_q;
		len_n    = len_q;
		only_n   = only_q;
		seen_n   = seen_q;
		sat_n    = sat_q;
		fin_char = 1'b0;

		if (!space) begin
			seen_n = 1'b1;
			if (dig) begin
				fin_char = (phase_q == PH_LETTERS);
				phase_n  = PH_DIGITS;
				count_n  = csat ? '1 : m10[CNT_W-1:0];
				sat_n    = sat_q | csat;
			end else begin
				only_n = 1'b0;
				if (low) begin
					if (phase_q == PH_DIGITS) begin
						phase_n = PH_LETTERS;
						len_n   = 2'd1;
						first_n = char_s1;
					end else if (phase_q == PH_LETTERS) begin
						if (len_q == 2'd0) begin
							first_n = char_s1;
						end else if (len_q == 2'd1) begin
							second_n = char_s1;
						end
						if (len_q != 2'd3) begin
							len_n = len_q + 2'd1;
						end
					end
				end else begin
					fin_char = (phase_q == PH_LETTERS);
					phase_n  = PH_IDLE;
				end
			end
		end

		fin     = fin_char || (last_s1 && phase_n == PH_LETTERS);
		unit    = unit_decode(len_n, first_n, second_n);
		tok_bad = (count_q == '0) || (unit == UNIT_NONE);
		inv_n   = inv_q | (fin && tok_bad);
		mul     = fin && !tok_bad;
		emit    = mul || last_s1;

		if (!seen_n) begin
			status = ST_EMPTY;
		end else if (only_n) begin
			status = ST_PLAIN;
		end else if (inv_n) begin
			status = ST_INVALID;
		end else begin
			status = ST_PARSED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			count_q      <= '0;
			first_q      <= '0;
			second_q     <= '0;
			len_q        <= '0;
			only_q       <= 1'b1;
			seen_q       <= 1'b0;
			inv_q        <= 1'b0;
			sat_q        <= 1'b0;
			tok_valid_s2 <= 1'b0;
		end else begin
			if (consume) begin
				tok_valid_s2 <= emit;
				if (last_s1) begin
					phase_q  <= PH_IDLE;
					count_q  <= '0;
					first_q  <= '0;
					second_q <= '0;
					len_q    <= '0;
					only_q   <= 1'b1;
					seen_q   <= 1'b0;
					inv_q    <= 1'b0;
					sat_q    <= 1'b0;
				end else begin
					phase_q  <= phase_n;
					count_q  <= count_n;
					first_q  <= first_n;
					second_q <= second_n;
					len_q    <= len_n;
					only_q   <= only_n;
					seen_q   <= seen_n;
					inv_q    <= inv_n;
					sat_q    <= sat_n;
				end
			end else if (tok_ready) begin
				tok_valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (consume) begin
			tok_s2.mul    <= mul;
			tok_s2.count  <= count_q;
			tok_s2.unit   <= unit;
			tok_s2.last   <= last_s1;
			tok_s2.status <= status;
			tok_s2.plain  <= count_n;
			tok_s2.sat    <= sat_n;
		end
	end

	assign tok_valid = tok_valid_s2;
	assign tok       = tok_s2;

endmodule

/* design/dtp_mul.sv */
// ----------------------------------------------------------------------------
// dtp_mul: token count times unit
// Two 32x25 partial products in one stage, recombined, shifted and saturated
// to 64 bits in the next.
// ----------------------------------------------------------------------------
module dtp_mul (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           tok_valid,
	output logic           tok_ready,
	input  dtp_pkg::tok_t  tok,
	output logic           prod_valid,
	input  logic           prod_ready,
	output dtp_pkg::prod_t prod
);
	import dtp_pkg::*;

	localparam int FULL_W = PART_W + HALF_W + 1;
	localparam int WIDE_W = FULL_W + (1 << SHIFT_W);

	logic             v_s3, v_s4;
	part_t            part_s3;
	prod_t            prod_s4;
	logic             ready3, ready4;
	logic [ODD_W-1:0] odd;
	logic [FULL_W-1:0] full;
	logic [WIDE_W-1:0] wide;
	logic              psat;

	assign ready4    = !v_s4 || prod_ready;
	assign ready3    = !v_s3 || ready4;
	assign tok_ready = ready3;
	assign odd       = unit_odd(tok.unit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (ready3) begin
				v_s3 <= tok_valid;
			end
			if (ready4) begin
				v_s4 <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready3 && tok_valid) begin
			part_s3.mul    <= tok.mul;
			part_s3.hi     <= PART_W'(tok.count[CNT_W-1:HALF_W]) * PART_W'(odd);
			part_s3.lo     <= PART_W'(tok.count[HALF_W-1:0]) * PART_W'(odd);
			part_s3.shift  <= unit_shift(tok.unit);
			part_s3.last   <= tok.last;
			part_s3.status <= tok.status;
			part_s3.plain  <= tok.plain;
			part_s3.sat    <= tok.sat;
		end
	end

	always_comb begin
		full = FULL_W'({part_s3.hi, {HALF_W{1'b0}}}) + FULL_W'(part_s3.lo);
		wide = WIDE_W'(full) << part_s3.shift;
		psat = |wide[WIDE_W-1:CNT_W];
	end

	always_ff @(posedge clk) begin
		if (ready4 && v_s3) begin
			prod_s4.mul    <= part_s3.mul;
			prod_s4.prod   <= psat ? '1 : wide[CNT_W-1:0];
			prod_s4.psat   <= part_s3.mul & psat;
			prod_s4.last   <= part_s3.last;
			prod_s4.status <= part_s3.status;
			prod_s4.plain  <= part_s3.plain;
			prod_s4.sat    <= part_s3.sat;
		end
	end

	assign prod_valid = v_s4;
	assign prod       = prod_s4;

endmodule

/* design/dtp_accum.sv */
// ----------------------------------------------------------------------------
// dtp_accum: running total and result register
// Saturating sum of token products; forms the result at the end of a string
// and holds it in the output register until taken.
// ----------------------------------------------------------------------------
module dtp_accum (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    prod_valid,
	output logic                    prod_ready,
	input  dtp_pkg::prod_t          prod,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [dtp_pkg::CNT_W-1:0] interval_ms,
	output dtp_pkg::status_t        status,
	output logic                    overflow
);
	import dtp_pkg::*;

	logic [CNT_W-1:0] total_q, tot_n;
	logic             acc_sat_q, sat_all;
	logic [CNT_W:0]   sum;
	logic             ssat, take, out_free;
	logic             out_valid_q;
	logic [CNT_W-1:0] interval_q;
	status_t          status_q;
	logic             overflow_q;

	assign out_free   = !out_valid_q || out_ready;
	assign prod_ready = !prod.last || out_free;
	assign take       = prod_valid && prod_ready;

	always_comb begin
		sum     = {1'b0, total_q} + {1'b0, prod.prod};
		ssat    = prod.mul & sum[CNT_W];
		tot_n   = !prod.mul ? total_q : (ssat ? '1 : sum[CNT_W-1:0]);
		sat_all = acc_sat_q | prod.psat | ssat | prod.sat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q     <= '0;
			acc_sat_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				if (prod.last) begin
					total_q   <= '0;
					acc_sat_q <= 1'b0;
				end else begin
					total_q   <= tot_n;
					acc_sat_q <= acc_sat_q | prod.psat | ssat;
				end
			end
			if (take && prod.last) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && prod.last) begin
			status_q   <= prod.status;
			overflow_q <= (prod.status == ST_EMPTY) ? 1'b0 : sat_all;
			case (prod.status)
				ST_PARSED: interval_q <= tot_n;
				ST_PLAIN:  interval_q <= prod.plain;
				default:   interval_q <= '0;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign interval_ms = interval_q;
	assign status      = status_q;
	assign overflow    = overflow_q;

endmodule

/* design/duration_text_to_ms_parser_top.sv */
// ----------------------------------------------------------------------------
// duration_text_to_ms_parser_top: duration text to milliseconds
// Streams a duration string one character per transaction and returns one
// result transaction per string.
// ----------------------------------------------------------------------------
// Takes one character every clock cycle with no gaps between strings while
// the input is not stalled. The result for a string passes the input
// register, the scanner's token register, the partial-product and saturation
// registers of the count-times-unit multiplier (split into two 32x25 partial
// products) and the saturating accumulator into the output register, and
// leaves on the master side. Input stalls only when a finished result waits in
// the output register and a further end of string reaches the accumulator.
module duration_text_to_ms_parser_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] char_code
	input  logic        s_axis_tlast,  // is_last
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata   // [63:0] interval_ms, [65:64] status, [66] overflow
);
	import dtp_pkg::*;

	logic             tok_valid, tok_ready;
	tok_t             tok;
	logic             prod_valid, prod_ready;
	prod_t            prod;
	logic [CNT_W-1:0] interval_ms;
	status_t          status;
	logic             overflow;

	dtp_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.char_code (s_axis_tdata),
		.is_last   (s_axis_tlast),
		.tok_valid (tok_valid),
		.tok_ready (tok_ready),
		.tok       (tok)
	);

	dtp_mul u_mul (
		.clk        (clk),
		.arst_n     (arst_n),
		.tok_valid  (tok_valid),
		.tok_ready  (tok_ready),
		.tok        (tok),
		.prod_valid (prod_valid),
		.prod_ready (prod_ready),
		.prod       (prod)
	);

	dtp_accum u_accum (
		.clk         (clk),
		.arst_n      (arst_n),
		.prod_valid  (prod_valid),
		.prod_ready  (prod_ready),
		.prod        (prod),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.interval_ms (interval_ms),
		.status      (status),
		.overflow    (overflow)
	);

	assign m_axis_tdata = {5'b0, overflow, status, interval_ms};

endmodule

/* tb/duration_text_to_ms_parser_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// duration_text_to_ms_parser_top_tb: self-checking bench for the duration parser
// Sends duration strings one character per transaction. A short directed
// table comes first, then random well-formed, broken and noise strings. The
// bench predicts interval, status and overflow for every string and checks each
// result transaction against that prediction, or against the table for typed
// directed rows; both sides stall at random until the last third of the random characters.
// ----------------------------------------------------------------------------
module duration_text_to_ms_parser_top_tb;
	import dtp_pkg::*;

	localparam int DIR_ROWS   = 8;
	localparam int RAND_CHARS = 600;
	localparam int MAX_PRINTS = 40;

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_A     = 8'h61;
	localparam logic [7:0] CH_Z     = 8'h7a;

	localparam logic [63:0] PER_MS = 64'd1;
	localparam logic [63:0] PER_S  = 64'd1000;
	localparam logic [63:0] PER_M  = 64'd60000;
	localparam logic [63:0] PER_H  = 64'd3600000;
	localparam logic [63:0] PER_D  = 64'd86400000;
	localparam logic [63:0] PER_W  = 64'd604800000;
	localparam logic [63:0] PER_Y  = 64'd31536000000;

	typedef enum logic [1:0] {
		SCAN_IDLE,
		SCAN_DIGITS,
		SCAN_LETTERS
	} scan_t;

	typedef struct packed {
		logic [63:0] ms;
		status_t     status;
		logic        ovf;
	} duration_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;  // [7:0] char_code
	logic        s_axis_tlast = 1'b0;   // is_last
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [71:0] m_axis_tdata;          // [63:0] interval_ms, [65:64] status, [66] overflow

	duration_text_to_ms_parser_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// directed strings; expectations are used only where typed is set
	string dir_text [DIR_ROWS] = '{" ", "0", "1ms2s3m", "1\t5h1d 1w1y", "0s", "7x",
		"\377", "600000000y"};
	bit dir_typed [DIR_ROWS] = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1};
	duration_result_t dir_result [DIR_ROWS] = '{
		'{64'd0, ST_EMPTY, 1'b0},
		'{64'd0, ST_PLAIN, 1'b0},
		'{64'd0, ST_PARSED, 1'b0},
		'{64'd0, ST_PARSED, 1'b0},
		'{64'd0, ST_INVALID, 1'b0},
		'{64'd0, ST_INVALID, 1'b0},
		'{64'd0, ST_PARSED, 1'b0},
		'{64'hffff_ffff_ffff_ffff, ST_PARSED, 1'b1}
	};
	string unit_names [7] = '{"ms", "s", "m", "h", "d", "w", "y"};

	duration_result_t pending_intervals [$];
	logic [7:0]       text_q [$];

	int          src_idle_pct;
	int          snk_idle_pct;
	int unsigned error_count;
	int unsigned chars_sent;
	int unsigned strings_sent;
	int unsigned results_checked;
	int unsigned status_seen [4];
	int unsigned overflow_seen;

	// parser state of the predictor
	scan_t       tok_phase;
	logic [63:0] tok_count;
	logic [63:0] total_ms;
	logic [7:0]  unit_c0;
	logic [7:0]  unit_c1;
	logic [1:0]  unit_len;
	bit          digits_only;
	bit          got_char;
	bit          string_bad;
	bit          saturated;

	task automatic report_error(input string what);
		error_count++;
		if (error_count <= MAX_PRINTS) begin
			$display("ERROR @%0t: %s", $time, what);
		end
	endtask

	task automatic clear_parse;
		tok_phase   = SCAN_IDLE;
		tok_count   = '0;
		total_ms    = '0;
		unit_c0     = '0;
		unit_c1     = '0;
		unit_len    = '0;
		digits_only = 1'b1;
		got_char    = 1'b0;
		string_bad  = 1'b0;
		saturated   = 1'b0;
	endtask

	function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s[64]) begin
			saturated = 1'b1;
			return '1;
		end
		return s[63:0];
	endfunction

	function automatic logic [63:0] mul_sat(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		if (|p[127:64]) begin
			saturated = 1'b1;
			return '1;
		end
		return p[63:0];
	endfunction

	function automatic logic [63:0] unit_factor;
		logic [63:0] f;
		f = '0;
		if (unit_len == 2'd2 && unit_c0 == CH_M && unit_c1 == CH_S) begin
			f = PER_MS;
		end else if (unit_len == 2'd1) begin
			case (unit_c0)
				CH_S: f = PER_S;
				CH_M: f = PER_M;
				CH_H: f = PER_H;
				CH_D: f = PER_D;
				CH_W: f = PER_W;
				CH_Y: f = PER_Y;
				default: f = '0;
			endcase
		end
		return f;
	endfunction

	task automatic close_token;
		if (tok_phase == SCAN_LETTERS) begin
			if (tok_count == '0 || unit_factor() == '0) begin
				string_bad = 1'b1;
			end else begin
				total_ms = add_sat(total_ms, mul_sat(tok_count, unit_factor()));
			end
		end
		tok_phase = SCAN_IDLE;
	endtask

	task automatic predict_interval(input logic [7:0] c, input logic last, output bit done,
			output duration_result_t r);
		bit space;
		space = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
		done = 1'b0;
		r = '0;
		if (!space) begin
			got_char = 1'b1;
			if (c >= CH_0 && c <= CH_9) begin
				if (tok_phase == SCAN_LETTERS) close_token();
				if (tok_phase != SCAN_DIGITS) begin
					tok_count = '0;
					tok_phase = SCAN_DIGITS;
				end
				tok_count = add_sat(mul_sat(tok_count, 64'd10), 64'(c - CH_0));
			end else begin
				digits_only = 1'b0;
				if (c >= CH_A && c <= CH_Z) begin
					if (tok_phase == SCAN_DIGITS) begin
						tok_phase = SCAN_LETTERS;
						unit_len = '0;
					end
					if (tok_phase == SCAN_LETTERS) begin
						if (unit_len == 2'd0) unit_c0 = c;
						else if (unit_len == 2'd1) unit_c1 = c;
						if (unit_len != 2'd3) unit_len++;
					end
				end else begin
					close_token();
				end
			end
		end
		if (last) begin
			done = 1'b1;
			if (!got_char) begin
				r = '{64'd0, ST_EMPTY, 1'b0};
			end else if (digits_only) begin
				r = '{tok_count, ST_PLAIN, saturated};
			end else begin
				close_token();
				if (string_bad) r = '{64'd0, ST_INVALID, saturated};
				else r = '{total_ms, ST_PARSED, saturated};
			end
			clear_parse();
		end
	endtask

	task automatic send_char(input logic [7:0] c, input logic last, output bit done,
			output duration_result_t r);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= c;
		s_axis_tlast  <= last;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		chars_sent++;
		predict_interval(c, last, done, r);
	endtask

	function automatic logic [7:0] pick_space;
		if ($urandom_range(0, 1)) return CH_SPACE;
		return 8'(CH_TAB + $urandom_range(0, 4));
	endfunction

	task automatic add_count;
		int n;
		case ($urandom_range(0, 14))
			0: n = 0;
			1: n = $urandom_range(10, 21);
			default: n = $urandom_range(1, 3);
		endcase
		if (n == 0) begin
			text_q.push_back(CH_0);
		end else begin
			if ($urandom_range(0, 9) == 0) text_q.push_back(CH_0);
			text_q.push_back(8'(CH_0 + $urandom_range(1, 9)));
			repeat (n - 1) text_q.push_back(8'(CH_0 + $urandom_range(0, 9)));
		end
	endtask

	task automatic add_unit;
		string u;
		u = unit_names[$urandom_range(0, 6)];
		for (int i = 0; i < u.len(); i++) text_q.push_back(u[i]);
	endtask

	task automatic add_letters(input int n);
		repeat (n) text_q.push_back(8'(CH_A + $urandom_range(0, 25)));
	endtask

	task automatic build_string;
		int kind;
		text_q.delete();
		kind = $urandom_range(0, 99);
		if (kind < 65) begin
			repeat ($urandom_range(1, 4)) begin
				if ($urandom_range(0, 4) == 0) text_q.push_back(pick_space());
				add_count();
				if ($urandom_range(0, 9) == 0) add_letters($urandom_range(1, 3));
				else add_unit();
			end
		end else if (kind < 75) begin
			repeat (($urandom_range(0, 3) == 0) ? $urandom_range(19, 22) : $urandom_range(1, 6))
				text_q.push_back(8'(CH_0 + $urandom_range(0, 9)));
		end else if (kind < 85) begin
			repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom_range(0, 255)));
		end else if (kind < 90) begin
			repeat ($urandom_range(1, 3)) text_q.push_back(pick_space());
		end else begin
			repeat ($urandom_range(2, 6)) begin
				case ($urandom_range(0, 3))
					0: add_count();
					1: add_unit();
					2: add_letters($urandom_range(1, 4));
					default: text_q.push_back(8'($urandom_range(0, 255)));
				endcase
			end
		end
	endtask

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
	end

	always @(posedge clk) begin : result_check
		duration_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_checked++;
			status_seen[m_axis_tdata[65:64]]++;
			if (m_axis_tdata[66]) overflow_seen++;
			if (pending_intervals.size() == 0) begin
				report_error($sformatf("result 0x%h with no string pending", m_axis_tdata));
			end else begin
				want = pending_intervals.pop_front();
				if (m_axis_tdata[63:0] !== want.ms)
					report_error($sformatf("interval_ms %0d, expected %0d",
						m_axis_tdata[63:0], want.ms));
				if (m_axis_tdata[65:64] !== want.status)
					report_error($sformatf("status %0d, expected %s",
						m_axis_tdata[65:64], want.status.name()));
				if (m_axis_tdata[66] !== want.ovf)
					report_error($sformatf("overflow %b, expected %b",
						m_axis_tdata[66], want.ovf));
				if (m_axis_tdata[71:67] !== '0)
					report_error($sformatf("pad bits %b not zero", m_axis_tdata[71:67]));
			end
		end
	end

	initial begin
		bit               done;
		duration_result_t r;
		int unsigned      dir_chars;
		string            t;
		clear_parse();
		src_idle_pct = 23;
		snk_idle_pct = 47;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int row = 0; row < DIR_ROWS; row++) begin
			t = dir_text[row];
			for (int i = 0; i < t.len(); i++) begin
				send_char(t[i], i == t.len() - 1, done, r);
				if (done) pending_intervals.push_back(dir_typed[row] ? dir_result[row] : r);
			end
			strings_sent++;
		end
		dir_chars = chars_sent;

		while (chars_sent - dir_chars < RAND_CHARS) begin
			if (chars_sent - dir_chars >= 2 * RAND_CHARS / 3) begin
				src_idle_pct = 0;
				snk_idle_pct = 0;
			end else if (chars_sent - dir_chars >= RAND_CHARS / 3) begin
				src_idle_pct = 47;
				snk_idle_pct = 23;
			end
			build_string();
			foreach (text_q[i]) begin
				send_char(text_q[i], i == text_q.size() - 1, done, r);
				if (done) pending_intervals.push_back(r);
			end
			strings_sent++;
		end
		s_axis_tvalid <= 1'b0;

		while (pending_intervals.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("Sent %0d strings (%0d characters), checked %0d results, %0d errors",
			strings_sent, chars_sent, results_checked, error_count);
		$display("Status parsed/plain/invalid/empty: %0d/%0d/%0d/%0d, saturated: %0d",
			status_seen[ST_PARSED], status_seen[ST_PLAIN], status_seen[ST_INVALID],
			status_seen[ST_EMPTY], overflow_seen);
		if (error_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("Timeout: %0d results still pending", pending_intervals.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule
